>>> rtl/core/route_table_prefix_lookup_macros.svh
// Assertion helpers for the route table. Both expect clk and rst_n in scope.
`ifndef ROUTE_TABLE_PREFIX_LOOKUP_MACROS_SVH
`define ROUTE_TABLE_PREFIX_LOOKUP_MACROS_SVH

// Same-cycle implication.
`define RTPL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RTPL_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rtpl_pkg.sv
package rtpl_pkg;

  localparam int ROUTE_ENTRIES = 16;
  localparam int IDX_W         = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  localparam int ADDR_W   = 32;
  localparam int METRIC_W = 16;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [STATUS_W-1:0] status_t;

  localparam cmd_t CMD_ADD    = 2'd0;
  localparam cmd_t CMD_REMOVE = 2'd1;
  localparam cmd_t CMD_LOOKUP = 2'd2;

  localparam status_t ST_DONE      = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;
  localparam status_t ST_NO_ROUTE  = 2'd3;

  typedef struct packed {
    logic [ADDR_W-1:0]   network;
    logic [ADDR_W-1:0]   mask;
    logic [ADDR_W-1:0]   gateway;
    logic [METRIC_W-1:0] metric;
  } route_t;

endpackage

>>> rtl/core/route_table_prefix_lookup.sv
// IPv4 route table with longest-prefix-match lookup. Raise start with a command word on
// the in_ ports while busy is low; the word is taken at that edge. Every command returns
// exactly one result word, shown on out_hop_addr/out_status for a single cycle with
// out_strobe high; the receiver cannot stall it, so capture it then. Operation, with
// ROUTE_ENTRIES = N (16): add walks the valid bits from entry 0 and claims the first free
// slot, or reports a full table when none is free; remove walks the entry memory one
// read per cycle and stops at the first valid entry whose network matches, or reports
// not found after entry N-1; lookup always reads all N entries. The entry memory is
// single-port and read one entry per cycle. busy drops in the cycle that shows the
// result, so the next command may start there. Valid bits clear at reset and no clearing
// pass is needed. Write the default gateway on the cfg_ port only while no command is in
// flight; cfg_ready is always high.
module route_table_prefix_lookup (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [rtpl_pkg::CMD_W-1:0]     in_cmd,
  input  logic [rtpl_pkg::ADDR_W-1:0]    in_net_address,
  input  logic [rtpl_pkg::ADDR_W-1:0]    in_net_mask,
  input  logic [rtpl_pkg::ADDR_W-1:0]    in_gateway_addr,
  input  logic [rtpl_pkg::METRIC_W-1:0]  in_route_metric,
  input  logic [rtpl_pkg::ADDR_W-1:0]    in_dest_addr,
  output logic                           out_strobe,
  output logic [rtpl_pkg::ADDR_W-1:0]    out_hop_addr,
  output logic [rtpl_pkg::STATUS_W-1:0]  out_status,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rtpl_pkg::ADDR_W-1:0]    cfg_default_gateway
);
  import rtpl_pkg::*;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ROUTE_ENTRIES - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_SCAN
  } state_t;

  // Sequencer state
  state_t                    state_r, state_nxt;
  logic [ROUTE_ENTRIES-1:0]  valid_r, valid_nxt;
  logic [IDX_W-1:0]          cnt_r, cnt_nxt;
  logic                      iss_on_r, iss_on_nxt;   // read issue still running
  logic                      rd_on_r, rd_on_nxt;     // memory word due this cycle
  logic [IDX_W-1:0]          rd_idx_r, rd_idx_nxt;

  // Captured command word
  cmd_t                      cmd_r, cmd_nxt;
  logic [ADDR_W-1:0]         net_r, net_nxt;
  logic [ADDR_W-1:0]         mask_r, mask_nxt;
  logic [ADDR_W-1:0]         gw_r, gw_nxt;
  logic [METRIC_W-1:0]       metric_r, metric_nxt;
  logic [ADDR_W-1:0]         dest_r, dest_nxt;

  // Best match so far
  logic                      best_found_r, best_found_nxt;
  logic [ADDR_W-1:0]         best_mask_r, best_mask_nxt;
  logic [METRIC_W-1:0]       best_met_r, best_met_nxt;
  logic [ADDR_W-1:0]         best_hop_r, best_hop_nxt;

  // Result word and config register
  logic                      out_strobe_r, out_strobe_nxt;
  logic [ADDR_W-1:0]         out_hop_r, out_hop_nxt;
  status_t                   out_status_r, out_status_nxt;
  logic [ADDR_W-1:0]         dflt_gw_r;

  // Entry memory: one port, read data registered
  route_t                    route_mem [ROUTE_ENTRIES];
  route_t                    rd_ent_r;
  logic                      mem_we;
  logic                      mem_re;
  route_t                    mem_wdata;

  logic                      accept;
  logic                      rd_live;
  logic                      rd_match;
  logic                      rd_better;
  logic                      rd_last;
  logic [ADDR_W-1:0]         rd_hop;
  logic                      fin_found;
  logic [ADDR_W-1:0]         fin_hop;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  assign out_strobe   = out_strobe_r;
  assign out_hop_addr = out_hop_r;
  assign out_status   = out_status_r;

  // Valid bits do not move during a scan, so sample them at the returned index.
  assign rd_live  = rd_on_r && valid_r[rd_idx_r];
  assign rd_last  = (rd_idx_r == LAST_IDX);
  assign rd_match = rd_live && ((dest_r & rd_ent_r.mask) == rd_ent_r.network);
  // First match taken; later ones need a longer mask, or equal mask and lower metric.
  assign rd_better = !best_found_r
                  || (rd_ent_r.mask > best_mask_r)
                  || ((rd_ent_r.mask == best_mask_r) && (rd_ent_r.metric < best_met_r));
  assign rd_hop    = (rd_ent_r.gateway != '0) ? rd_ent_r.gateway : dest_r;

  assign fin_found = best_found_r || (rd_match && rd_better);
  assign fin_hop   = (rd_match && rd_better) ? rd_hop : best_hop_r;

  assign mem_wdata = '{network: net_r, mask: mask_r, gateway: gw_r, metric: metric_r};

  always_comb begin
    state_nxt       = state_r;
    valid_nxt       = valid_r;
    cnt_nxt         = cnt_r;
    iss_on_nxt      = iss_on_r;
    rd_on_nxt       = 1'b0;
    rd_idx_nxt      = rd_idx_r;
    cmd_nxt         = cmd_r;
    net_nxt         = net_r;
    mask_nxt        = mask_r;
    gw_nxt          = gw_r;
    metric_nxt      = metric_r;
    dest_nxt        = dest_r;
    best_found_nxt  = best_found_r;
    best_mask_nxt   = best_mask_r;
    best_met_nxt    = best_met_r;
    best_hop_nxt    = best_hop_r;
    out_strobe_nxt  = 1'b0;
    out_hop_nxt     = out_hop_r;
    out_status_nxt  = out_status_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd_nxt        = in_cmd;
          net_nxt        = in_net_address;
          mask_nxt       = in_net_mask;
          gw_nxt         = in_gateway_addr;
          metric_nxt     = in_route_metric;
          dest_nxt       = in_dest_addr;
          cnt_nxt        = '0;
          best_found_nxt = 1'b0;
          case (in_cmd) inside
            CMD_ADD: begin
              state_nxt = S_ADD;
            end
            CMD_REMOVE, CMD_LOOKUP: begin
              state_nxt  = S_SCAN;
              iss_on_nxt = 1'b1;
            end
            default: begin
              // unused code: no table change, empty result
              out_strobe_nxt = 1'b1;
              out_hop_nxt    = '0;
              out_status_nxt = ST_DONE;
            end
          endcase
        end
      end

      S_ADD: begin
        if (!valid_r[cnt_r]) begin
          mem_we           = 1'b1;
          valid_nxt[cnt_r] = 1'b1;
          state_nxt        = S_IDLE;
          out_strobe_nxt   = 1'b1;
          out_hop_nxt      = '0;
          out_status_nxt   = ST_DONE;
        end else if (cnt_r == LAST_IDX) begin
          state_nxt      = S_IDLE;
          out_strobe_nxt = 1'b1;
          out_hop_nxt    = '0;
          out_status_nxt = ST_FULL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      S_SCAN: begin
        // Issue side: one read per cycle.
        if (iss_on_r) begin
          mem_re     = 1'b1;
          rd_on_nxt  = 1'b1;
          rd_idx_nxt = cnt_r;
          if (cnt_r == LAST_IDX) begin
            iss_on_nxt = 1'b0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        // Evaluate side: the word read last cycle.
        if (rd_on_r) begin
          if (cmd_r == CMD_REMOVE) begin
            if (rd_live && (rd_ent_r.network == net_r)) begin
              valid_nxt[rd_idx_r] = 1'b0;
              state_nxt           = S_IDLE;
              iss_on_nxt          = 1'b0;
              rd_on_nxt           = 1'b0;
              out_strobe_nxt      = 1'b1;
              out_hop_nxt         = '0;
              out_status_nxt      = ST_DONE;
            end else if (rd_last) begin
              state_nxt      = S_IDLE;
              rd_on_nxt      = 1'b0;
              out_strobe_nxt = 1'b1;
              out_hop_nxt    = '0;
              out_status_nxt = ST_NOT_FOUND;
            end
          end else begin
            if (rd_match && rd_better) begin
              best_found_nxt  = 1'b1;
              best_mask_nxt   = rd_ent_r.mask;
              best_met_nxt    = rd_ent_r.metric;
              best_hop_nxt    = rd_hop;
            end
            if (rd_last) begin
              state_nxt      = S_IDLE;
              rd_on_nxt      = 1'b0;
              out_strobe_nxt = 1'b1;
              out_hop_nxt    = fin_found ? fin_hop : dflt_gw_r;
              out_status_nxt = fin_found ? ST_DONE : ST_NO_ROUTE;
            end
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      iss_on_r     <= 1'b0;
      rd_on_r      <= 1'b0;
      out_strobe_r <= 1'b0;
      dflt_gw_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      iss_on_r     <= iss_on_nxt;
      rd_on_r      <= rd_on_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        dflt_gw_r <= cfg_default_gateway;
      end
    end
    cnt_r         <= cnt_nxt;
    rd_idx_r      <= rd_idx_nxt;
    cmd_r         <= cmd_nxt;
    net_r         <= net_nxt;
    mask_r        <= mask_nxt;
    gw_r          <= gw_nxt;
    metric_r      <= metric_nxt;
    dest_r        <= dest_nxt;
    best_found_r  <= best_found_nxt;
    best_mask_r   <= best_mask_nxt;
    best_met_r    <= best_met_nxt;
    best_hop_r    <= best_hop_nxt;
    out_hop_r     <= out_hop_nxt;
    out_status_r  <= out_status_nxt;
  end

  // Entry memory. Writes and reads never meet in one command, and busy keeps the
  // next command's first read behind an add's write.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      route_mem[cnt_r] <= mem_wdata;
    end
    if (mem_re) begin
      rd_ent_r <= route_mem[cnt_r];
    end
  end

  `include "route_table_prefix_lookup_macros.svh"

  // A full report means every slot really was taken.
  `RTPL_ASSERT_IMP(a_full_means_all_valid,
                   out_strobe_r && (out_status_r == ST_FULL), &valid_r,
                   "table full reported with a free slot")
  // Add and remove failures carry no next hop.
  `RTPL_ASSERT_IMP(a_err_zero_hop,
                   out_strobe_r && ((out_status_r == ST_FULL) ||
                                    (out_status_r == ST_NOT_FOUND)),
                   out_hop_r == '0,
                   "nonzero next hop on a failed add or remove")
  // A successful add sets exactly one more valid bit.
  `RTPL_ASSERT_IMP(a_add_grows,
                   out_strobe_r && (cmd_r == CMD_ADD) && (out_status_r == ST_DONE),
                   $countones(valid_r) == ($countones($past(valid_r)) + 1),
                   "add did not claim exactly one slot")
  // An accepted word is either in work or already answered next cycle.
  `RTPL_ASSERT_NXT(a_accept_tracked, accept, busy || out_strobe_r,
                   "accepted word dropped")

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import rtpl_pkg::*;

  // The package names no code for the spare command value, so name it here.
  localparam cmd_t        CMD_UNUSED     = 2'd3;
  // Starting metric of a lookup scan; any stored 16-bit metric beats it.
  localparam int unsigned METRIC_CEILING = 999999;
  // Cycles with no word moved before the run is declared hung.
  localparam int          WATCHDOG_LIMIT = 4000;
  // Extra cycles after the last result; a full scan is the longest command.
  localparam int          SETTLE_CYCLES  = ROUTE_ENTRIES + 4;

  typedef struct {
    cmd_t                cmd;
    logic [ADDR_W-1:0]   net_address;
    logic [ADDR_W-1:0]   net_mask;
    logic [ADDR_W-1:0]   gateway_addr;
    logic [METRIC_W-1:0] route_metric;
    logic [ADDR_W-1:0]   dest_addr;
  } route_word_t;

  typedef struct {
    logic [ADDR_W-1:0] hop_addr;
    status_t           status;
  } hop_result_t;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    in_cmd;
  logic [ADDR_W-1:0]   in_net_address;
  logic [ADDR_W-1:0]   in_net_mask;
  logic [ADDR_W-1:0]   in_gateway_addr;
  logic [METRIC_W-1:0] in_route_metric;
  logic [ADDR_W-1:0]   in_dest_addr;
  logic                out_strobe;
  logic [ADDR_W-1:0]   out_hop_addr;
  logic [STATUS_W-1:0] out_status;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [ADDR_W-1:0]   cfg_default_gateway;

  // Shadow copy of the route table and the default gateway register.
  bit                tbl_valid [ROUTE_ENTRIES];
  route_t            tbl_route [ROUTE_ENTRIES];
  logic [ADDR_W-1:0] shadow_default_gw;

  // Results predicted for accepted command words, oldest first.
  hop_result_t       pending_hops[$];
  hop_result_t       oldest_hop;
  int                err_count;
  int                quiet_cycles;

  route_table_prefix_lookup i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_cmd              (in_cmd),
    .in_net_address      (in_net_address),
    .in_net_mask         (in_net_mask),
    .in_gateway_addr     (in_gateway_addr),
    .in_route_metric     (in_route_metric),
    .in_dest_addr        (in_dest_addr),
    .out_strobe          (out_strobe),
    .out_hop_addr        (out_hop_addr),
    .out_status          (out_status),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_default_gateway (cfg_default_gateway)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [ADDR_W-1:0] got,
                                 input logic [ADDR_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
    err_count++;
  endtask

  // Advance the shadow table by one command word and return its result.
  // Mirrors the hardware scan order: lowest index first, strict compares.
  function automatic hop_result_t predict_hop(input route_word_t w);
    hop_result_t       res;
    logic [ADDR_W-1:0] best_mask;
    int unsigned       best_met;
    res.hop_addr = '0;
    res.status   = ST_DONE;
    case (w.cmd)
      CMD_ADD: begin
        res.status = ST_FULL;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          if (res.status == ST_FULL && !tbl_valid[i]) begin
            tbl_route[i].network = w.net_address;
            tbl_route[i].mask    = w.net_mask;
            tbl_route[i].gateway = w.gateway_addr;
            tbl_route[i].metric  = w.route_metric;
            tbl_valid[i]         = 1'b1;
            res.status           = ST_DONE;
          end
        end
      end
      CMD_REMOVE: begin
        res.status = ST_NOT_FOUND;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          if (res.status == ST_NOT_FOUND && tbl_valid[i] &&
              tbl_route[i].network == w.net_address) begin
            tbl_valid[i] = 1'b0;
            res.status   = ST_DONE;
          end
        end
      end
      CMD_LOOKUP: begin
        res.hop_addr = shadow_default_gw;
        res.status   = ST_NO_ROUTE;
        best_mask    = '0;
        best_met     = METRIC_CEILING;
        for (int i = 0; i < ROUTE_ENTRIES; i++) begin
          if (tbl_valid[i] && (w.dest_addr & tbl_route[i].mask) == tbl_route[i].network &&
              (tbl_route[i].mask > best_mask ||
               (tbl_route[i].mask == best_mask && tbl_route[i].metric < best_met))) begin
            best_mask    = tbl_route[i].mask;
            best_met     = 32'(tbl_route[i].metric);
            // A zero gateway marks a directly connected net: hop to the host itself.
            res.hop_addr = (tbl_route[i].gateway != '0) ? tbl_route[i].gateway : w.dest_addr;
            res.status   = ST_DONE;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic route_word_t mk_word(input cmd_t cmd, input logic [ADDR_W-1:0] net,
                                          input logic [ADDR_W-1:0] mask,
                                          input logic [ADDR_W-1:0] gw,
                                          input logic [METRIC_W-1:0] metric,
                                          input logic [ADDR_W-1:0] dest);
    route_word_t w;
    w.cmd          = cmd;
    w.net_address  = net;
    w.net_mask     = mask;
    w.gateway_addr = gw;
    w.route_metric = metric;
    w.dest_addr    = dest;
    return w;
  endfunction

  // Pick a random live table entry, or -1 when the table is empty.
  function automatic int pick_live_entry();
    int live;
    int nth;
    live = 0;
    foreach (tbl_valid[i]) if (tbl_valid[i]) live++;
    if (live == 0) return -1;
    nth = int'($urandom_range(live - 1));
    foreach (tbl_valid[i]) begin
      if (tbl_valid[i]) begin
        if (nth == 0) return i;
        nth--;
      end
    end
    return -1;
  endfunction

  // Present one command word and hold it until the block takes it. Start is
  // left high on return; the caller either presents the next word in the same
  // step or drops start through hold_off or wait_drained.
  task automatic send_word(input route_word_t w);
    start           <= 1'b1;
    in_cmd          <= w.cmd;
    in_net_address  <= w.net_address;
    in_net_mask     <= w.net_mask;
    in_gateway_addr <= w.gateway_addr;
    in_route_metric <= w.route_metric;
    in_dest_addr    <= w.dest_addr;
    do @(posedge clk); while (busy);
    pending_hops.push_back(predict_hop(w));
  endtask

  task automatic hold_off(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Drop start and wait until every predicted result has come back, then let
  // the block settle so a register write lands on an idle engine.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_hops.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write the default gateway register; call only on an idle block.
  task automatic write_default_gw(input logic [ADDR_W-1:0] value);
    cfg_valid           <= 1'b1;
    cfg_default_gateway <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid         <= 1'b0;
    shadow_default_gw  = value;
  endtask

  // Empty table: a lookup falls through to the reset default gateway, a remove
  // finds nothing, and the spare command code leaves the table alone with an empty result.
  task automatic test_reset_state();
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, '0));
    send_word(mk_word(CMD_REMOVE, '1, '1, '1, '1, '1));
    send_word(mk_word(CMD_UNUSED, '1, '1, '1, '1, '1));
    wait_drained();
  endtask

  // Move the default gateway through its extremes and check misses pick it up.
  task automatic test_default_gateway();
    write_default_gw('1);
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, '1));
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h0000_0000));
    wait_drained();
    write_default_gw(32'h5A5A_A5A5);
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, $urandom));
    wait_drained();
    write_default_gw($urandom);
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, $urandom));
    wait_drained();
    write_default_gw('0);
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'hA5A5_5A5A));
    wait_drained();
  endtask

  // Hand-built routes: metric ties, a longer prefix, a direct net, a default
  // route, a zero mask with a nonzero net, a host route, and duplicate removes.
  task automatic test_prefix_rules();
    send_word(mk_word(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, '1, '1, '0));
    send_word(mk_word(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0102_0304, '0, '0));
    send_word(mk_word(CMD_ADD, 32'h0A00_0000, 32'hFF00_0000, 32'h0506_0708, '0, '0));
    send_word(mk_word(CMD_ADD, 32'h0A0B_0000, 32'hFFFF_0000, '0, 16'd5, '0));
    send_word(mk_word(CMD_ADD, '0, '0, 32'hC0A8_0001, 16'h1234, '0));
    send_word(mk_word(CMD_ADD, 32'h1111_1111, '0, 32'h0909_0909, '0, '0));
    send_word(mk_word(CMD_ADD, '1, '1, '0, '0, '0));
    // Direct net under the longer prefix: hop equals the destination.
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A0B_0C0D));
    // Equal masks: lower metric wins, then the earlier entry on a tie.
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A7F_0000));
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, '1));
    // Falls to the zero-mask route rather than the default gateway.
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h1234_5678));
    // Remove frees only the lowest matching entry each time.
    send_word(mk_word(CMD_REMOVE, 32'h0A00_0000, '0, '0, '0, '0));
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h0A7F_0000));
    send_word(mk_word(CMD_REMOVE, 32'h0A00_0000, '1, '1, '1, '1));
    send_word(mk_word(CMD_LOOKUP, '0, '0, '0, '0, 32'h0AFF_FFFF));
    wait_drained();
  endtask

  // Random command words. Most are well formed: prefix masks, nets aligned to
  // them, removes of live nets and lookups that land inside live routes.
  task automatic run_random_phase(input int n_words, input int add_pct,
                                  input int remove_pct, input int idle_pct);
    route_word_t w;
    int          roll;
    int          pick;
    int          plen;
    for (int n = 0; n < n_words; n++) begin
      w    = mk_word(CMD_LOOKUP, $urandom, $urandom, $urandom, METRIC_W'($urandom),
                     $urandom);
      roll = $urandom_range(99);
      if (roll < 2) begin
        w.cmd = CMD_UNUSED;
      end else if (roll < 2 + add_pct) begin
        w.cmd = CMD_ADD;
      end else if (roll < 2 + add_pct + remove_pct) begin
        w.cmd = CMD_REMOVE;
      end
      pick = pick_live_entry();
      case (w.cmd)
        CMD_ADD: begin
          if ($urandom_range(99) < 85) begin
            plen       = $urandom_range(32);
            w.net_mask = (plen == 0) ? '0 : ({ADDR_W{1'b1}} << (ADDR_W - plen));
            // Reuse a live net now and then to nest prefixes and force ties.
            if (pick >= 0 && $urandom_range(1) == 1) w.net_address = tbl_route[pick].network;
            w.net_address = w.net_address & w.net_mask;
            if ($urandom_range(4) == 0) w.gateway_addr = '0;
            if ($urandom_range(2) == 0) w.route_metric = METRIC_W'($urandom_range(3));
          end
        end
        CMD_REMOVE: begin
          if (pick >= 0 && $urandom_range(3) != 0) w.net_address = tbl_route[pick].network;
        end
        CMD_LOOKUP: begin
          if (pick >= 0 && $urandom_range(3) != 0) begin
            w.dest_addr = (tbl_route[pick].network & tbl_route[pick].mask) |
                          ($urandom & ~tbl_route[pick].mask);
          end
        end
        default: ;
      endcase
      send_word(w);
      if ($urandom_range(99) < idle_pct) hold_off($urandom_range(1, 17));
    end
    wait_drained();
  endtask

  // Mixed traffic across several gateway settings; the add-heavy phase drives
  // the table full, the remove-heavy one drains it again.
  task automatic test_random_traffic();
    write_default_gw('1);
    run_random_phase(300, 45, 15, 30);
    write_default_gw($urandom);
    run_random_phase(300, 20, 40, 0);
    write_default_gw('0);
    run_random_phase(300, 30, 30, 50);
  endtask

  // Close with words presented back to back and no sender gaps at all.
  task automatic test_back_to_back();
    write_default_gw(32'hA5A5_5A5A);
    run_random_phase(320, 30, 25, 0);
  endtask

  // Compare each result word with the oldest prediction; the block cannot be
  // stalled, so sample the strobe at every edge.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (pending_hops.size() == 0) begin
        report_mismatch("unexpected result word", out_hop_addr, '0);
      end else begin
        oldest_hop = pending_hops.pop_front();
        if (out_hop_addr !== oldest_hop.hop_addr)
          report_mismatch("hop_addr", out_hop_addr, oldest_hop.hop_addr);
        if (out_status !== oldest_hop.status)
          report_mismatch("status", ADDR_W'(out_status), ADDR_W'(oldest_hop.status));
      end
    end
  end

  // Hang detector: clear on any accepted word, result or register write.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    err_count           = 0;
    shadow_default_gw   = '0;
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
    rst_n               <= 1'b0;
    start               <= 1'b0;
    in_cmd              <= CMD_ADD;
    in_net_address      <= '0;
    in_net_mask         <= '0;
    in_gateway_addr     <= '0;
    in_route_metric     <= '0;
    in_dest_addr        <= '0;
    cfg_valid           <= 1'b0;
    cfg_default_gateway <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_default_gateway();
    test_prefix_rules();
    test_random_traffic();
    test_back_to_back();

    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/rtpl_pkg.sv
rtl/core/route_table_prefix_lookup.sv
test/testbench.sv
